### hdl/isml_pkg.sv
// Shared types, sizes and codes for the interval set merge and lookup block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package isml_pkg;

    localparam int MAX_RANGES    = 16;
    localparam int POS_W         = 32;
    localparam int OP_W          = 2;
    localparam int RANGE_COUNT_W = 5;
    localparam int IDX_W         = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W         = $clog2(MAX_RANGES + 1);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RANGES);
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_SHORTEN = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

    // Verdicts of the shared compare unit for one stored entry.
    typedef struct packed {
        logic             ends_below; // entry ends more than one below the new start
        logic             after;      // entry starts more than one above the new end
        logic             holds;      // start < key <= end
        logic             covers;     // start <= key <= end
        logic [POS_W-1:0] min_start;
        logic [POS_W-1:0] max_end;
    } isml_cmp_t;

    // One read and one write port of the range store.
    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             we_start;
        logic             we_end;
        logic [IDX_W-1:0] wr_addr;
        logic [POS_W-1:0] wr_start;
        logic [POS_W-1:0] wr_end;
    } isml_mem_req_t;

endpackage

### hdl/isml_cmd_if.sv
// Command channel: operation code and two positions, valid/ready handshake.
// Depends on isml_pkg for field widths.
`timescale 1ns / 1ps

interface isml_cmd_if;
    import isml_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] last_pos;

    modport source (output valid, output op, output first_pos, output last_pos, input ready);
    modport sink   (input valid, input op, input first_pos, input last_pos, output ready);
endinterface

### hdl/isml_rsp_if.sv
// Response channel: coverage answer, set bounds, count and overflow flag.
// Depends on isml_pkg for field widths.
`timescale 1ns / 1ps

interface isml_rsp_if;
    import isml_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     covered;
    logic [POS_W-1:0]         lowest_bound;
    logic [POS_W-1:0]         highest_bound;
    logic [RANGE_COUNT_W-1:0] range_count;
    logic                     overflowed;

    modport source (output valid, output covered, output lowest_bound, output highest_bound,
                    output range_count, output overflowed, input ready);
    modport sink   (input valid, input covered, input lowest_bound, input highest_bound,
                    input range_count, input overflowed, output ready);
endinterface

### hdl/isml_store.sv
// Range store: start and end arrays, one write port and one registered read port.
// Depends on isml_pkg for the request struct and sizes.
`timescale 1ns / 1ps

module isml_store (
    input  logic                   clk,
    input  isml_pkg::isml_mem_req_t req,
    output logic [isml_pkg::POS_W-1:0] rd_start,
    output logic [isml_pkg::POS_W-1:0] rd_end
);
    import isml_pkg::*;

    logic [POS_W-1:0] start_mem [MAX_RANGES];
    logic [POS_W-1:0] end_mem   [MAX_RANGES];

    always_ff @(posedge clk)
    begin
        if (req.we_start)
        begin
            start_mem[req.wr_addr] <= req.wr_start;
        end
        if (req.we_end)
        begin
            end_mem[req.wr_addr] <= req.wr_end;
        end
        rd_start <= start_mem[req.rd_addr];
        rd_end   <= end_mem[req.rd_addr];
    end

endmodule

### hdl/isml_cmp.sv
// Shared compare unit: classifies one stored entry against the item's positions.
// Depends on isml_pkg for the verdict struct.
`timescale 1ns / 1ps

module isml_cmp (
    input  logic [isml_pkg::POS_W-1:0] ent_start,
    input  logic [isml_pkg::POS_W-1:0] ent_end,
    input  logic [isml_pkg::POS_W-1:0] key_a,
    input  logic [isml_pkg::POS_W-1:0] key_b,
    output isml_pkg::isml_cmp_t        res
);
    import isml_pkg::*;

    logic [POS_W:0] end_inc;
    logic [POS_W:0] key_b_inc;

    // Touch tests run one bit wider so that an end of all ones does not wrap.
    assign end_inc   = {1'b0, ent_end} + {{POS_W{1'b0}}, 1'b1};
    assign key_b_inc = {1'b0, key_b} + {{POS_W{1'b0}}, 1'b1};

    always_comb
    begin
        res.ends_below = end_inc < {1'b0, key_a};
        res.after      = key_b_inc < {1'b0, ent_start};
        res.holds      = (ent_start < key_a) && (ent_end >= key_a);
        res.covers     = (ent_start <= key_a) && (key_a <= ent_end);
        res.min_start  = (ent_start < key_a) ? ent_start : key_a;
        res.max_end    = (ent_end > key_b) ? ent_end : key_b;
    end

endmodule

### hdl/interval_set_merge_lookup_unit.sv
// Top level of the interval set merge and lookup block: sequencer, bounds and result register.
// Depends on isml_pkg, isml_cmd_if, isml_rsp_if, isml_store and isml_cmp.
`timescale 1ns / 1ps

//  channel | role  | word carries
//  --------+-------+---------------------------------------------------------
//  cmd     | sink  | op, first_pos, last_pos
//  rsp     | source| covered, lowest_bound, highest_bound, range_count, overflowed
//
// One word is in flight at a time; cmd.ready is high only while the sequencer is idle.
// Query and shorten walk the stored entries once; add walks them and may then move
// entries up or down, as each entry visit goes through the one read port and the one
// compare unit. A reversed add or an unused op goes straight to the final state.
// Reset clears count, bounds, overflow flag and handshake state; the store is not cleared.
// A finished word holds in the final state until the output register is free.

module interval_set_merge_lookup_unit (
    input  logic       clk,
    input  logic       rst_n,
    isml_cmd_if.sink   cmd,
    isml_rsp_if.source rsp
);
    import isml_pkg::*;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
    localparam logic [ST_W-1:0] ST_SCAN = 3'd1;   // walk all entries through the compare unit
    localparam logic [ST_W-1:0] ST_FIX  = 3'd2;   // apply the verdict of the walk
    localparam logic [ST_W-1:0] ST_COPY = 3'd3;   // move entries up or down
    localparam logic [ST_W-1:0] ST_PUT  = 3'd4;   // write an inserted range
    localparam logic [ST_W-1:0] ST_FIN  = 3'd5;   // hand the result to the output register

    logic [ST_W-1:0] state_reg;
    logic [ST_W-1:0] state_next;

    // Word being worked on
    logic [OP_W-1:0]  op_reg;
    logic [POS_W-1:0] a_reg;
    logic [POS_W-1:0] b_reg;

    // Architectural state
    logic [CNT_W-1:0] count_reg;
    logic [POS_W-1:0] low_reg;
    logic [POS_W-1:0] high_reg;
    logic             ovf_reg;

    // Walk and copy control
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] left_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pidx_reg;
    logic             up_reg;
    logic             ins_reg;
    logic [CNT_W-1:0] shift_reg;

    // Scan results
    logic [CNT_W-1:0] lo_reg;
    logic [CNT_W-1:0] ov_reg;
    logic [POS_W-1:0] ms_reg;
    logic [POS_W-1:0] me_reg;
    logic             hold_reg;
    logic [IDX_W-1:0] hold_idx_reg;
    logic [POS_W-1:0] first_start_reg;
    logic             cov_reg;

    // Output register
    logic                     out_valid_reg;
    logic                     out_cov_reg;
    logic [POS_W-1:0]         out_low_reg;
    logic [POS_W-1:0]         out_high_reg;
    logic [RANGE_COUNT_W-1:0] out_cnt_reg;
    logic                     out_ovf_reg;

    logic             cmd_fire;
    logic             skip_walk;
    logic             load_out;
    logic             walk_done;
    logic             copy_done;
    logic [CNT_W-1:0] hi_idx;
    logic [POS_W-1:0] p_end;
    logic [POS_W-1:0] rd_start;
    logic [POS_W-1:0] rd_end;
    isml_cmp_t        cmp;
    isml_mem_req_t    mem_req;

    isml_store u_store (
        .clk      (clk),
        .req      (mem_req),
        .rd_start (rd_start),
        .rd_end   (rd_end)
    );

    isml_cmp u_cmp (
        .ent_start (rd_start),
        .ent_end   (rd_end),
        .key_a     (a_reg),
        .key_b     (b_reg),
        .res       (cmp)
    );

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;

    // Drop a reversed add or an unused op without walking the store.
    assign skip_walk = ((cmd.op == OP_ADD) && (cmd.first_pos > cmd.last_pos))
                       || !(cmd.op inside {OP_ADD, OP_SHORTEN, OP_QUERY});

    assign load_out  = (state_reg == ST_FIN) && (!out_valid_reg || rsp.ready);
    assign walk_done = (idx_reg >= count_reg) && !pend_reg;
    assign copy_done = (left_reg == '0) && !pend_reg;
    assign hi_idx    = lo_reg + ov_reg;
    assign p_end     = (a_reg == POS_MAX) ? POS_MAX : a_reg + {{(POS_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = skip_walk ? ST_FIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (walk_done)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                state_next = ST_FIN;
                if ((op_reg == OP_ADD) && ((ov_reg != '0) || (count_reg < MAX_CNT)))
                begin
                    state_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                if (copy_done)
                begin
                    state_next = ins_reg ? ST_PUT : ST_FIN;
                end
            end
            ST_PUT:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Store port control
    always_comb
    begin
        mem_req          = '0;
        mem_req.rd_addr  = idx_reg[IDX_W-1:0];
        case (state_reg)
            ST_COPY:
            begin
                if (pend_reg)
                begin
                    mem_req.we_start = 1'b1;
                    mem_req.we_end   = 1'b1;
                    mem_req.wr_addr  = up_reg ? pidx_reg + {{(IDX_W-1){1'b0}}, 1'b1}
                                              : pidx_reg - shift_reg[IDX_W-1:0];
                    mem_req.wr_start = rd_start;
                    mem_req.wr_end   = rd_end;
                end
            end
            ST_FIX:
            begin
                if ((op_reg == OP_ADD) && (ov_reg != '0))
                begin
                    mem_req.we_start = 1'b1;
                    mem_req.we_end   = 1'b1;
                    mem_req.wr_addr  = lo_reg[IDX_W-1:0];
                    mem_req.wr_start = ms_reg;
                    mem_req.wr_end   = me_reg;
                end
                else if ((op_reg == OP_SHORTEN) && (count_reg == '0))
                begin
                    mem_req.we_start = 1'b1;
                    mem_req.we_end   = 1'b1;
                    mem_req.wr_addr  = '0;
                    mem_req.wr_start = a_reg;
                    mem_req.wr_end   = p_end;
                end
                else if ((op_reg == OP_SHORTEN) && hold_reg)
                begin
                    mem_req.we_start = 1'b1;
                    mem_req.wr_addr  = hold_idx_reg;
                    mem_req.wr_start = a_reg;
                end
            end
            ST_PUT:
            begin
                mem_req.we_start = 1'b1;
                mem_req.we_end   = 1'b1;
                mem_req.wr_addr  = lo_reg[IDX_W-1:0];
                mem_req.wr_start = a_reg;
                mem_req.wr_end   = b_reg;
            end
            default:
            begin
                mem_req.we_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            low_reg       <= POS_MAX;
            high_reg      <= '0;
            ovf_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_SCAN, ST_COPY:
                begin
                    // Issue one read a cycle; the compare unit sees it the cycle after.
                    if ((state_reg == ST_SCAN) ? (idx_reg < count_reg) : (left_reg != '0))
                    begin
                        pend_reg <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                end
                ST_FIX:
                begin
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (ov_reg != '0)
                            begin
                                count_reg <= count_reg - (ov_reg - {{(CNT_W-1){1'b0}}, 1'b1});
                            end
                            else if (count_reg >= MAX_CNT)
                            begin
                                ovf_reg <= 1'b1;
                            end
                            else
                            begin
                                count_reg <= count_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                            end
                            if ((ov_reg != '0) || (count_reg < MAX_CNT))
                            begin
                                if (a_reg < low_reg)
                                begin
                                    low_reg <= a_reg;
                                end
                                if (b_reg > high_reg)
                                begin
                                    high_reg <= b_reg;
                                end
                            end
                        end
                        OP_SHORTEN:
                        begin
                            if (count_reg == '0)
                            begin
                                count_reg <= {{(CNT_W-1){1'b0}}, 1'b1};
                                low_reg   <= a_reg;
                                if (p_end > high_reg)
                                begin
                                    high_reg <= p_end;
                                end
                            end
                            else
                            begin
                                low_reg <= (hold_reg && (hold_idx_reg == '0)) ? a_reg
                                                                              : first_start_reg;
                            end
                        end
                        default:
                        begin
                            pend_reg <= 1'b0;
                        end
                    endcase
                end
                default:
                begin
                    pend_reg <= 1'b0;
                end
            endcase
        end
    end

    // Payload and walk bookkeeping, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                op_reg   <= cmd.op;
                a_reg    <= cmd.first_pos;
                b_reg    <= cmd.last_pos;
                idx_reg  <= '0;
                lo_reg   <= '0;
                ov_reg   <= '0;
                hold_reg <= 1'b0;
                cov_reg  <= 1'b0;
                ins_reg  <= 1'b0;
            end
            ST_SCAN:
            begin
                if (idx_reg < count_reg)
                begin
                    pidx_reg <= idx_reg[IDX_W-1:0];
                    idx_reg  <= idx_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                end
                if (pend_reg)
                begin
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (cmp.ends_below)
                            begin
                                lo_reg <= lo_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                            end
                            else if (!cmp.after)
                            begin
                                if (ov_reg == '0)
                                begin
                                    ms_reg <= cmp.min_start;
                                end
                                me_reg <= cmp.max_end;
                                ov_reg <= ov_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                            end
                        end
                        OP_SHORTEN:
                        begin
                            if (cmp.holds && !hold_reg)
                            begin
                                hold_reg     <= 1'b1;
                                hold_idx_reg <= pidx_reg;
                            end
                            if (pidx_reg == '0)
                            begin
                                first_start_reg <= rd_start;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (cmp.covers)
                            begin
                                cov_reg <= 1'b1;
                            end
                        end
                        default:
                        begin
                            cov_reg <= 1'b0;
                        end
                    endcase
                end
            end
            ST_FIX:
            begin
                // Merge: close the gap left by the absorbed entries, from hi upward.
                // Insert: open a slot at lo, from the top entry downward.
                if (ov_reg != '0)
                begin
                    shift_reg <= ov_reg - {{(CNT_W-1){1'b0}}, 1'b1};
                    idx_reg   <= hi_idx;
                    left_reg  <= count_reg - hi_idx;
                    up_reg    <= 1'b0;
                end
                else
                begin
                    shift_reg <= '0;
                    idx_reg   <= count_reg - {{(CNT_W-1){1'b0}}, 1'b1};
                    left_reg  <= count_reg - lo_reg;
                    up_reg    <= 1'b1;
                    ins_reg   <= 1'b1;
                end
            end
            ST_COPY:
            begin
                if (left_reg != '0)
                begin
                    pidx_reg <= idx_reg[IDX_W-1:0];
                    idx_reg  <= up_reg ? idx_reg - {{(CNT_W-1){1'b0}}, 1'b1}
                                       : idx_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                    left_reg <= left_reg - {{(CNT_W-1){1'b0}}, 1'b1};
                end
            end
            default:
            begin
                if (load_out)
                begin
                    out_cov_reg  <= cov_reg;
                    out_low_reg  <= low_reg;
                    out_high_reg <= high_reg;
                    out_cnt_reg  <= RANGE_COUNT_W'(count_reg);
                    out_ovf_reg  <= ovf_reg;
                end
            end
        endcase
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.covered       = out_cov_reg;
    assign rsp.lowest_bound  = out_low_reg;
    assign rsp.highest_bound = out_high_reg;
    assign rsp.range_count   = out_cnt_reg;
    assign rsp.overflowed    = out_ovf_reg;

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("range count above store depth");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(ovf_reg))
        else $error("overflow flag cleared");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(mem_req.we_start || mem_req.we_end))
        else $error("store written while idle");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start work");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("result not held after completion");
`endif

endmodule
